// ===== sv/polyphonic_wavetable_voice_mixer_top_assert.svh =====
// assertion macros for the voice mixer checker
`ifndef POLYPHONIC_WAVETABLE_VOICE_MIXER_TOP_ASSERT_SVH
`define POLYPHONIC_WAVETABLE_VOICE_MIXER_TOP_ASSERT_SVH

// clocked check, suspended while reset is asserted
`define PWVM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pwvm check failed");

// clocked check that also runs during reset
`define PWVM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pwvm reset check failed");

`endif

// ===== sv/pwvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwvm_pkg
// Shared constants, request codes and field types of the wavetable voice mixer.
// ----------------------------------------------------------------------------
package pwvm_pkg;

  localparam int VOICE_LOG2 = 3;
  localparam int NVOICES    = 1 << VOICE_LOG2;
  localparam int OCTAVES    = 2;
  localparam int NKEYS      = 16 * OCTAVES;

  localparam int REQ_W    = 3;
  localparam int KEY_W    = 5;
  localparam int PHASE_W  = 16;
  localparam int TADDR_W  = 8;
  localparam int SAMPLE_W = 8;
  localparam int KEYMAP_W = 32;
  localparam int MIX_W    = SAMPLE_W + VOICE_LOG2;

  typedef logic [REQ_W-1:0]    req_type_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [PHASE_W-1:0]  phase_t;
  typedef logic [TADDR_W-1:0]  taddr_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [KEYMAP_W-1:0] keymap_t;
  typedef logic [VOICE_LOG2-1:0] voice_idx_t;
  typedef logic [MIX_W-1:0]    mix_t;

  localparam req_type_t REQ_TICK    = 3'd0;
  localparam req_type_t REQ_PRESS   = 3'd1;
  localparam req_type_t REQ_RELEASE = 3'd2;
  localparam req_type_t REQ_LOAD    = 3'd3;
  localparam req_type_t REQ_CLEAR   = 3'd4;

  localparam key_t KEY_FREE = '0;

  function automatic logic key_usable(input key_t key);
    key_usable = (key != KEY_FREE) && (int'(key) < NKEYS);
  endfunction

endpackage

// ===== sv/pwvm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwvm_if
// Valid/ready channels carrying request words in and result words out.
// ----------------------------------------------------------------------------
interface pwvm_req_if;
  logic                valid;
  logic                ready;
  pwvm_pkg::req_type_t req_type;
  pwvm_pkg::key_t      key_number;
  pwvm_pkg::phase_t    phase_step;
  pwvm_pkg::taddr_t    table_addr;
  pwvm_pkg::sample_t   table_data;

  modport source (output valid, req_type, key_number, phase_step, table_addr,
                  table_data, input ready);
  modport sink   (input valid, req_type, key_number, phase_step, table_addr,
                  table_data, output ready);
endinterface

interface pwvm_res_if;
  logic              valid;
  logic              ready;
  pwvm_pkg::sample_t audio_sample;
  logic              sample_valid;
  logic              voice_found;
  pwvm_pkg::keymap_t held_keys;

  modport source (output valid, audio_sample, sample_valid, voice_found,
                  held_keys, input ready);
  modport sink   (input valid, audio_sample, sample_valid, voice_found,
                  held_keys, output ready);
endinterface

// ===== sv/polyphonic_wavetable_voice_mixer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyphonic_wavetable_voice_mixer_top
// Eight-voice wavetable synthesizer with key allocation and a shared mixer.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries request words (tick, press, release, load, clear all) and
//   res_o returns exactly one result word per request, in order.
//   A tick walks the voices one per cycle through a single phase adder and
//   one wave table read port: the voice visits, then a drain state for the
//   registered table read, then a done state that posts the result. Press
//   and release scan the voices one per cycle and stop at the first hit; the
//   scan is skipped when the key is zero or off the keyboard or a press finds
//   the key already held. Load, clear all and the spare codes go straight to
//   the done state. One request is in flight at a time; req_i.ready is high
//   only while the sequencer is idle, so the next request can be taken in
//   the cycle after a result is posted.
//   After reset the wave table is zeroed by a clearing pass over all 256
//   entries, one entry per cycle, during which no request is taken.
//   A finished result sits in the output register until res_o.ready; the
//   next request is still taken and worked, but its result waits in the
//   sequencer while the register is full, and no further request is taken
//   until that result is posted.
// ----------------------------------------------------------------------------
module polyphonic_wavetable_voice_mixer_top (
  input logic       clk_i,
  input logic       rst_ni,
  pwvm_req_if.sink  req_i,
  pwvm_res_if.source res_o
);
  import pwvm_pkg::*;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_TICK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam voice_idx_t LAST_VOICE = voice_idx_t'(NVOICES - 1);
  localparam taddr_t     LAST_ADDR  = '1;

  logic [2:0] state_q, state_d;
  voice_idx_t vidx_q, vidx_d;
  taddr_t     init_cnt_q;
  req_type_t  req_q;
  key_t       key_q;
  phase_t     step_q;
  mix_t       mix_q, mix_d;
  logic       acc_en_q, acc_en_d;
  logic       found_q, found_d;

  phase_t  phase_q [NVOICES];
  phase_t  vstep_q [NVOICES];
  key_t    vkey_q  [NVOICES];
  keymap_t keymap_q;

  logic    out_valid_q;
  sample_t out_sample_q;
  logic    out_svalid_q;
  logic    out_found_q;
  keymap_t out_held_q;

  logic    accept;
  logic    post;
  logic    mem_we;
  taddr_t  mem_waddr;
  sample_t mem_wdata;
  sample_t mem_rdata;
  taddr_t  mem_raddr;
  logic    scan_hit;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign post        = (state_q == ST_DONE) && (!out_valid_q || res_o.ready);

  // clearing pass owns the write port until the table is zeroed
  assign mem_we    = (state_q == ST_INIT) || (accept && req_i.req_type == REQ_LOAD);
  assign mem_waddr = (state_q == ST_INIT) ? init_cnt_q : req_i.table_addr;
  assign mem_wdata = (state_q == ST_INIT) ? '0 : req_i.table_data;
  assign mem_raddr = phase_q[vidx_q][PHASE_W-1 -: TADDR_W];

  pwvm_wave_mem u_wave_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign scan_hit = (req_q == REQ_PRESS) ? (vkey_q[vidx_q] == KEY_FREE)
                                         : (vkey_q[vidx_q] == key_q);

  always_comb begin
    state_d  = state_q;
    vidx_d   = vidx_q;
    mix_d    = mix_q;
    acc_en_d = acc_en_q;
    found_d  = found_q;
    case (state_q)
      ST_INIT: begin
        if (init_cnt_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          vidx_d   = '0;
          mix_d    = '0;
          acc_en_d = 1'b0;
          found_d  = 1'b0;
          state_d  = ST_DONE;
          case (req_i.req_type)
            REQ_TICK: state_d = ST_TICK;
            REQ_PRESS: begin
              if (key_usable(req_i.key_number) && !keymap_q[req_i.key_number]) begin
                state_d = ST_SCAN;
              end
            end
            REQ_RELEASE: begin
              if (key_usable(req_i.key_number)) begin
                state_d = ST_SCAN;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_TICK: begin
        // table read data is registered and lags its address
        acc_en_d = 1'b1;
        if (acc_en_q) begin
          mix_d = mix_q + mix_t'(mem_rdata);
        end
        if (vidx_q == LAST_VOICE) begin
          state_d = ST_DRAIN;
        end else begin
          vidx_d = vidx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        mix_d    = mix_q + mix_t'(mem_rdata);
        acc_en_d = 1'b0;
        state_d  = ST_DONE;
      end
      ST_SCAN: begin
        if (scan_hit) begin
          found_d = 1'b1;
          state_d = ST_DONE;
        end else if (vidx_q == LAST_VOICE) begin
          state_d = ST_DONE;
        end else begin
          vidx_d = vidx_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (post) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      vidx_q     <= '0;
      init_cnt_q <= '0;
      acc_en_q   <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      vidx_q   <= vidx_d;
      acc_en_q <= acc_en_d;
      found_q  <= found_d;
      if (state_q == ST_INIT) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mix_q <= mix_d;
    if (accept) begin
      req_q  <= req_i.req_type;
      key_q  <= req_i.key_number;
      step_q <= req_i.phase_step;
    end
  end

  // voice registers and key bitmap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NVOICES; v++) begin
        phase_q[v] <= '0;
        vstep_q[v] <= '0;
        vkey_q[v]  <= KEY_FREE;
      end
      keymap_q <= '0;
    end else begin
      if (accept && req_i.req_type == REQ_CLEAR) begin
        for (int v = 0; v < NVOICES; v++) begin
          phase_q[v] <= '0;
          vstep_q[v] <= '0;
          vkey_q[v]  <= KEY_FREE;
        end
        keymap_q <= '0;
      end
      if (state_q == ST_TICK) begin
        phase_q[vidx_q] <= phase_q[vidx_q] + vstep_q[vidx_q];
      end
      if (state_q == ST_SCAN && scan_hit) begin
        if (req_q == REQ_PRESS) begin
          vkey_q[vidx_q]  <= key_q;
          vstep_q[vidx_q] <= step_q;
          keymap_q[key_q] <= 1'b1;
        end else begin
          vkey_q[vidx_q]  <= KEY_FREE;
          vstep_q[vidx_q] <= '0;
          phase_q[vidx_q] <= '0;
          keymap_q[key_q] <= 1'b0;
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (post) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (post) begin
      out_svalid_q <= (req_q == REQ_TICK);
      out_sample_q <= (req_q == REQ_TICK) ? mix_q[VOICE_LOG2 +: SAMPLE_W] : '0;
      out_found_q  <= found_q;
      out_held_q   <= keymap_q;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.audio_sample = out_sample_q;
  assign res_o.sample_valid = out_svalid_q;
  assign res_o.voice_found  = out_found_q;
  assign res_o.held_keys    = out_held_q;

endmodule

// ===== sv/pwvm_wave_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwvm_wave_mem
// Wave table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pwvm_wave_mem (
  input  logic              clk_i,
  input  logic              we_i,
  input  pwvm_pkg::taddr_t  waddr_i,
  input  pwvm_pkg::sample_t wdata_i,
  input  pwvm_pkg::taddr_t  raddr_i,
  output pwvm_pkg::sample_t rdata_o
);
  import pwvm_pkg::*;

  localparam int DEPTH = 1 << TADDR_W;

  sample_t mem [DEPTH];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/pwvm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwvm_checker
// Port-level checks of the voice mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "polyphonic_wavetable_voice_mixer_top_assert.svh"

module pwvm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input pwvm_pkg::sample_t audio_sample_i,
  input logic              sample_valid_i,
  input logic              voice_found_i,
  input pwvm_pkg::keymap_t held_keys_i
);
  import pwvm_pkg::*;

  // a tick never allocates or frees a voice
  `PWVM_ASSERT(a_tick_no_found, res_valid_i && sample_valid_i |-> !voice_found_i)

  // only a tick carries audio
  `PWVM_ASSERT(a_silent_non_tick, res_valid_i && !sample_valid_i |-> audio_sample_i == '0)

  // key zero marks a free voice and is never held
  `PWVM_ASSERT(a_key_zero_free, res_valid_i |-> !held_keys_i[0])

  // a stalled word holds
  `PWVM_ASSERT(a_hold_on_stall, res_valid_i && !res_ready_i |=>
               res_valid_i && $stable(held_keys_i) && $stable(audio_sample_i))

  // nothing is offered while reset holds
  `PWVM_ASSERT_RST(a_reset_quiet, !rst_ni |-> !res_valid_i)

endmodule

bind polyphonic_wavetable_voice_mixer_top pwvm_checker u_pwvm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .audio_sample_i(res_o.audio_sample),
  .sample_valid_i(res_o.sample_valid),
  .voice_found_i (res_o.voice_found),
  .held_keys_i   (res_o.held_keys)
);

// ===== tb/tb_voice_mix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voice_mix_checker
// Passive checker for the voice mixer. It watches both channels, keeps its
// own voices, key map and wave table, and works out the result word of
// every accepted request. Result words are compared in order, field by field.
// ----------------------------------------------------------------------------
module voice_mix_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pwvm_req_if  req_mon,
  pwvm_res_if  res_mon,
  output int   errors_o,
  output int   pending_o
);
  import pwvm_pkg::*;

  localparam int TABLE_DEPTH = 1 << TADDR_W;

  typedef struct packed {
    sample_t audio_sample;
    logic    sample_valid;
    logic    voice_found;
    keymap_t held_keys;
  } mix_result_t;

  phase_t      voice_phase [NVOICES];
  phase_t      voice_step  [NVOICES];
  key_t        voice_key   [NVOICES];
  sample_t     wave_mem    [TABLE_DEPTH];
  keymap_t     held_map;
  mix_result_t mix_expected_q [$];
  int          error_cnt;

  function automatic logic on_keyboard(input key_t key);
    return (key != KEY_FREE) && (int'(key) < NKEYS);
  endfunction

  task automatic release_all_voices();
    for (int v = 0; v < NVOICES; v++) begin
      voice_phase[v] = '0;
      voice_step[v]  = '0;
      voice_key[v]   = KEY_FREE;
    end
    held_map = '0;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_cnt++;
    $display("%0t ns voice mix: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic predict_voice_mix(input req_type_t kind, input key_t key,
                                   input phase_t step, input taddr_t addr,
                                   input sample_t data, output mix_result_t res);
    int unsigned mix_sum;
    res     = '0;
    mix_sum = 0;
    case (kind)
      REQ_TICK: begin
        // free voices sit at phase 0 and still add entry 0
        for (int v = 0; v < NVOICES; v++) begin
          mix_sum += wave_mem[voice_phase[v][PHASE_W-1 -: TADDR_W]];
          voice_phase[v] = voice_phase[v] + voice_step[v];
        end
        res.audio_sample = sample_t'(mix_sum >> VOICE_LOG2);
        res.sample_valid = 1'b1;
      end
      REQ_PRESS: begin
        if (on_keyboard(key) && !held_map[key]) begin
          for (int v = 0; v < NVOICES; v++) begin
            if (voice_key[v] == KEY_FREE) begin
              voice_key[v]  = key;
              voice_step[v] = step;
              held_map[key] = 1'b1;
              res.voice_found = 1'b1;
              break;
            end
          end
        end
      end
      REQ_RELEASE: begin
        if (on_keyboard(key)) begin
          for (int v = 0; v < NVOICES; v++) begin
            if (voice_key[v] == key) begin
              voice_key[v]   = KEY_FREE;
              voice_step[v]  = '0;
              voice_phase[v] = '0;
              held_map[key]  = 1'b0;
              res.voice_found = 1'b1;
              break;
            end
          end
        end
      end
      REQ_LOAD: begin
        wave_mem[addr] = data;
      end
      REQ_CLEAR: begin
        release_all_voices();
      end
      default: begin
      end
    endcase
    res.held_keys = held_map;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mix_result_t want;
    if (!rst_ni) begin
      release_all_voices();
      for (int a = 0; a < TABLE_DEPTH; a++) begin
        wave_mem[a] = '0;
      end
      mix_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (mix_expected_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding, held_keys",
                          res_mon.held_keys, '0);
        end else begin
          want = mix_expected_q.pop_front();
          if (res_mon.audio_sample !== want.audio_sample) begin
            report_mismatch("audio_sample", 32'(res_mon.audio_sample),
                            32'(want.audio_sample));
          end
          if (res_mon.sample_valid !== want.sample_valid) begin
            report_mismatch("sample_valid", 32'(res_mon.sample_valid),
                            32'(want.sample_valid));
          end
          if (res_mon.voice_found !== want.voice_found) begin
            report_mismatch("voice_found", 32'(res_mon.voice_found),
                            32'(want.voice_found));
          end
          if (res_mon.held_keys !== want.held_keys) begin
            report_mismatch("held_keys", res_mon.held_keys, want.held_keys);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_voice_mix(req_mon.req_type, req_mon.key_number, req_mon.phase_step,
                          req_mon.table_addr, req_mon.table_data, want);
        mix_expected_q.push_back(want);
      end
      pending_o <= mix_expected_q.size();
    end
    errors_o <= error_cnt;
  end

endmodule

// ===== tb/tb_polyphonic_wavetable_voice_mixer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyphonic_wavetable_voice_mixer_top
// Drives request words into the voice mixer and drains its result words.
// A directed opening covers key and table extremes, full voices, duplicate
// and stray keys, clear all and the spare codes; a random part follows with
// gaps on both sides and one long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_polyphonic_wavetable_voice_mixer_top;
  import pwvm_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 5;
  localparam int RANDOM_WORDS   = 550;
  localparam int IDLE_PCT       = 24;
  localparam int TX_QUIET_FROM  = 300;
  localparam int TX_QUIET_TO    = 400;
  localparam int RX_QUIET_FROM  = 320;
  localparam int RX_QUIET_TO    = 420;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 24;
  localparam int TIMEOUT_CYCLES = 200_000;

  // codes the block must ignore
  localparam req_type_t REQ_SPARE_FIRST = 3'd5;
  localparam req_type_t REQ_SPARE_LAST  = 3'd7;

  logic clk_i;
  logic rst_ni;
  int   n_sent;
  int   n_errors;
  int   n_pending;
  int   kind_cnt [1 << REQ_W];
  bit   hold_done;
  key_t pressed_keys [$];

  pwvm_req_if req_ch ();
  pwvm_res_if res_ch ();

  polyphonic_wavetable_voice_mixer_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  voice_mix_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_mon   (req_ch),
    .res_mon   (res_ch),
    .errors_o  (n_errors),
    .pending_o (n_pending)
  );

  always begin
    clk_i = 1'b0;
    #(CLK_PERIOD / 2);
    clk_i = 1'b1;
    #(CLK_PERIOD / 2);
  end

  task automatic send_request(input req_type_t kind, input key_t key, input phase_t step,
                              input taddr_t addr, input sample_t data);
    while (!(n_sent >= TX_QUIET_FROM && n_sent < TX_QUIET_TO) &&
           $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.key_number <= key;
    req_ch.phase_step <= step;
    req_ch.table_addr <= addr;
    req_ch.table_data <= data;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    n_sent <= n_sent + 1;
    kind_cnt[kind]++;
  endtask

  // result side: random stalls, one long hold-off, one stretch always ready
  initial begin
    res_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && n_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      res_ch.ready <= (n_sent >= RX_QUIET_FROM && n_sent < RX_QUIET_TO) ||
                      ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles, %0d words still outstanding",
             TIMEOUT_CYCLES, n_pending);
    $display("polyphonic_wavetable_voice_mixer_top: mismatch");
    $finish;
  end

  initial begin
    req_type_t kind;
    key_t      key;
    phase_t    step;
    taddr_t    addr;
    sample_t   data;
    int        pick;
    int        idx;
    int        spare_cnt;

    rst_ni            <= 1'b0;
    n_sent            <= 0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_TICK;
    req_ch.key_number <= KEY_FREE;
    req_ch.phase_step <= '0;
    req_ch.table_addr <= '0;
    req_ch.table_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening
    send_request(REQ_TICK, KEY_FREE, '0, '0, '0);
    send_request(REQ_LOAD, KEY_FREE, '0, 8'h00, 8'hFF);
    send_request(REQ_LOAD, KEY_FREE, '0, 8'hFF, 8'hFF);
    send_request(REQ_LOAD, KEY_FREE, '0, 8'h80, 8'h5A);
    send_request(REQ_LOAD, KEY_FREE, '0, 8'h01, 8'h00);
    send_request(REQ_TICK, KEY_FREE, '0, '0, '0);
    send_request(REQ_PRESS, KEY_FREE, 16'hFFFF, '0, '0);
    send_request(REQ_PRESS, key_t'(NKEYS - 1), 16'hFFFF, '0, '0);
    send_request(REQ_PRESS, key_t'(NKEYS - 1), 16'h1234, '0, '0);
    send_request(REQ_PRESS, key_t'(1), 16'h0000, '0, '0);
    // fill the remaining voices
    for (int k = 2; k < NVOICES; k++) begin
      send_request(REQ_PRESS, key_t'(k), phase_t'(k * 16'h0100), '0, '0);
    end
    send_request(REQ_PRESS, key_t'(NVOICES), 16'h8000, '0, '0);
    send_request(REQ_TICK, KEY_FREE, '0, '0, '0);
    send_request(REQ_TICK, KEY_FREE, '0, '0, '0);
    send_request(REQ_RELEASE, KEY_FREE, '0, '0, '0);
    send_request(REQ_RELEASE, key_t'(NVOICES + 1), '0, '0, '0);
    send_request(REQ_RELEASE, key_t'(NKEYS - 1), '0, '0, '0);
    send_request(REQ_TICK, KEY_FREE, '0, '0, '0);
    send_request(REQ_SPARE_FIRST, key_t'(3), 16'hFFFF, 8'hFF, 8'hFF);
    send_request(REQ_SPARE_LAST, key_t'(2), 16'hFFFF, 8'h00, 8'hFF);
    send_request(REQ_CLEAR, KEY_FREE, '0, '0, '0);
    send_request(REQ_TICK, KEY_FREE, '0, '0, '0);

    // random part: mostly ticks and key traffic with table loads mixed in
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(99);
      key  = key_t'($urandom_range(NKEYS - 1));
      step = phase_t'($urandom);
      addr = taddr_t'($urandom);
      data = sample_t'($urandom);
      if (pick < 42) begin
        kind = REQ_TICK;
      end else if (pick < 60) begin
        kind = REQ_PRESS;
        pressed_keys.push_back(key);
      end else if (pick < 74) begin
        kind = REQ_RELEASE;
        // mostly release a key that was pressed earlier
        if (pressed_keys.size() != 0 && $urandom_range(3) != 0) begin
          idx = $urandom_range(pressed_keys.size() - 1);
          key = pressed_keys[idx];
          pressed_keys.delete(idx);
        end
      end else if (pick < 94) begin
        kind = REQ_LOAD;
      end else if (pick < 97) begin
        kind = REQ_CLEAR;
        pressed_keys.delete();
      end else begin
        kind = req_type_t'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
      end
      send_request(kind, key, step, addr, data);
    end
    req_ch.valid <= 1'b0;

    do @(posedge clk_i); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    spare_cnt = 0;
    for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++) begin
      spare_cnt += kind_cnt[k];
    end
    $display("run covered %0d words: %0d ticks, %0d presses, %0d releases, %0d loads,",
             n_sent, kind_cnt[REQ_TICK], kind_cnt[REQ_PRESS], kind_cnt[REQ_RELEASE],
             kind_cnt[REQ_LOAD]);
    $display("%0d clears, %0d spare codes; result side held off %0d cycles once",
             kind_cnt[REQ_CLEAR], spare_cnt, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("polyphonic_wavetable_voice_mixer_top: match");
    end else begin
      $display("polyphonic_wavetable_voice_mixer_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== polyphonic_wavetable_voice_mixer_top.f =====
+incdir+sv
sv/pwvm_pkg.sv
sv/pwvm_if.sv
sv/pwvm_wave_mem.sv
sv/polyphonic_wavetable_voice_mixer_top.sv
sv/pwvm_checker.sv
tb/tb_voice_mix_checker.sv
tb/tb_polyphonic_wavetable_voice_mixer_top.sv
